### rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// shared types and codes for the positional stack edit core
// ----------------------------------------------------------------------------
package pse_pkg;

    // default and largest supported stack depth
    localparam int DEPTH_DEF = 16;
    localparam int DEPTH_MAX = 4096;

    // widest cell index carried on the broadcast control
    localparam int IDX_W = $clog2(DEPTH_MAX);

    localparam int WORD_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        M_PUSH   = 3'd0,
        M_POP    = 3'd1,
        M_DELETE = 3'd2,
        M_INSERT = 3'd3,
        M_READ   = 3'd4,
        M_CLEAR  = 3'd5
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,  // keep own word
        SH_LOAD = 2'd1,  // cell at 'at' takes the new word
        SH_DOWN = 2'd2,  // cells from 'at' upward take the upper neighbour
        SH_UP   = 2'd3   // cells above 'at' take the lower neighbour, 'at' takes the word
    } t_shift;

    typedef struct packed {
        t_shift             kind;
        logic [IDX_W-1:0]   at;
        logic [IDX_W-1:0]   sel;
        logic [WORD_W-1:0]  word;
    } t_cell_ctl;

endpackage

### rtl/pse_cell.sv
// ----------------------------------------------------------------------------
// pse_cell
// one stack entry: holds a word and trades it with its neighbours
// ----------------------------------------------------------------------------
module pse_cell #(
    parameter int INDEX = 0
) (
    input  logic                        i_clk,
    input  pse_pkg::t_cell_ctl          i_ctl,
    input  logic [pse_pkg::WORD_W-1:0]  i_from_up,
    input  logic [pse_pkg::WORD_W-1:0]  i_from_down,
    output logic [pse_pkg::WORD_W-1:0]  o_data,
    output logic [pse_pkg::WORD_W-1:0]  o_tap
);

    localparam int XW = pse_pkg::IDX_W;
    localparam logic [XW-1:0] MY_IDX = XW'(INDEX);

    logic [pse_pkg::WORD_W-1:0] r_data;
    logic [pse_pkg::WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.kind)
            pse_pkg::SH_LOAD: begin
                if (MY_IDX == i_ctl.at) begin
                    n_data = i_ctl.word;
                end
            end
            pse_pkg::SH_DOWN: begin
                if (MY_IDX >= i_ctl.at) begin
                    n_data = i_from_up;
                end
            end
            pse_pkg::SH_UP: begin
                if (MY_IDX > i_ctl.at) begin
                    n_data = i_from_down;
                end else if (MY_IDX == i_ctl.at) begin
                    n_data = i_ctl.word;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (MY_IDX == i_ctl.sel) ? r_data : '0;

endmodule

### rtl/positional_stack_edit_core.sv
// ----------------------------------------------------------------------------
// positional_stack_edit_core
// bounded stack of signed words with positional insert, run delete and read
// ----------------------------------------------------------------------------
// The stack lives in a row of DEPTH identical cells, cell 0 holding position 1.
// Every input transfer carries one operation and yields exactly one result
// transfer with the word read (popped or read, else 0), a status and the new
// fill count. Push, pop, read, insert, clear and every rejected operation do
// their work in the cycle of the input transfer: insert moves the entries from
// the position upward up by one place in that same cycle. A run delete of count
// entries shifts the upper cells down one place per cycle, the first step in
// the transfer cycle, so it occupies the cell row until the run is gone (count
// up to DEPTH); the input side is not ready during that time. A result passes
// a pending register and then the output register; a new input transfer is
// taken as soon as the pending register is free, even while a result still
// waits at the output. A new operation is thus taken only once the result of
// the last one has left the pending register.
// ----------------------------------------------------------------------------
module positional_stack_edit_core #(
    parameter int DEPTH = pse_pkg::DEPTH_DEF,
    // derived, not meant to be overridden
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int IN_W  = ((pse_pkg::MODE_W + 2 * CW + pse_pkg::WORD_W + 7) / 8) * 8,
    parameter int OUT_W = ((pse_pkg::WORD_W + pse_pkg::STAT_W + CW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // mode, position, count, value (lowest bit first), zero padded
    input  logic [IN_W-1:0]  s_axis_tdata,

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // read_value, status, fill_count (lowest bit first), zero padded
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int WW  = pse_pkg::WORD_W;
    localparam int SW  = pse_pkg::STAT_W;
    localparam int MW  = pse_pkg::MODE_W;
    localparam int XW  = pse_pkg::IDX_W;
    localparam int IW  = $clog2(DEPTH);

    // input field offsets
    localparam int POS_LO = MW;
    localparam int CNT_LO = MW + CW;
    localparam int VAL_LO = MW + 2 * CW;
    localparam int RES_W  = WW + SW + CW;

    localparam logic [CW-1:0] FULL_N = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_N  = CW'(1);

    typedef enum logic {
        S_IDLE,
        S_SHIFT
    } t_state;

    // input field split
    pse_pkg::t_mode     in_mode;
    logic [CW-1:0]      in_pos;
    logic [CW-1:0]      in_cnt;
    logic [WW-1:0]      in_word;

    // registers
    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_left;
    logic [IW-1:0]      r_at;
    logic               r_pend_valid;
    logic [WW-1:0]      r_pend_rv;
    pse_pkg::t_status   r_pend_st;
    logic [CW-1:0]      r_pend_fill;
    logic               r_o_valid;
    logic [RES_W-1:0]   r_o_data;

    // decode of the offered item
    logic [WW-1:0]      d_rv;
    pse_pkg::t_status   d_st;
    logic [CW-1:0]      d_fill;
    pse_pkg::t_shift    d_kind;
    logic [IW-1:0]      d_at;
    logic [CW-1:0]      d_left;
    logic [IW-1:0]      d_sel;

    logic               in_xfer;
    logic               out_free;
    logic [WW-1:0]      rd_word;
    logic [CW:0]        run_end;

    pse_pkg::t_cell_ctl cell_ctl;
    logic [WW-1:0]      cell_data [DEPTH];
    logic [WW-1:0]      cell_tap  [DEPTH];

    assign in_mode = pse_pkg::t_mode'(s_axis_tdata[MW-1:0]);
    assign in_pos  = s_axis_tdata[POS_LO +: CW];
    assign in_cnt  = s_axis_tdata[CNT_LO +: CW];
    assign in_word = s_axis_tdata[VAL_LO +: WW];

    // input taken only while the row is free and a pending slot is open
    assign s_axis_tready = (r_state == S_IDLE) && !r_pend_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_o_valid || m_axis_tready;

    // one past the last entry of a delete run
    assign run_end = {1'b0, in_pos} + {1'b0, in_cnt};

    // pop looks at the top entry, read at the given position
    always_comb begin
        if (in_mode == pse_pkg::M_POP) begin
            d_sel = IW'(r_count - ONE_N);
        end else begin
            d_sel = IW'(in_pos - ONE_N);
        end
    end

    // and-or over the cell taps, only the selected cell drives
    always_comb begin
        rd_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_word = rd_word | cell_tap[k];
        end
    end

    // operation decode against the current fill
    always_comb begin
        d_rv   = '0;
        d_st   = pse_pkg::ST_OK;
        d_fill = r_count;
        d_kind = pse_pkg::SH_HOLD;
        d_at   = '0;
        d_left = '0;
        case (in_mode)
            pse_pkg::M_PUSH: begin
                if (r_count >= FULL_N) begin
                    d_st = pse_pkg::ST_FULL;
                end else begin
                    d_kind = pse_pkg::SH_LOAD;
                    d_at   = IW'(r_count);
                    d_fill = r_count + ONE_N;
                end
            end
            pse_pkg::M_POP: begin
                if (r_count == '0) begin
                    d_st = pse_pkg::ST_EMPTY;
                end else begin
                    d_rv   = rd_word;
                    d_fill = r_count - ONE_N;
                end
            end
            pse_pkg::M_DELETE: begin
                if (r_count == '0) begin
                    d_st = pse_pkg::ST_EMPTY;
                end else if (in_pos == '0 || run_end > ({1'b0, r_count} + (CW+1)'(1))) begin
                    d_st = pse_pkg::ST_BAD;
                end else begin
                    d_fill = r_count - in_cnt;
                    if (in_cnt != '0) begin
                        // first shift step happens in the transfer cycle
                        d_kind = pse_pkg::SH_DOWN;
                        d_at   = IW'(in_pos - ONE_N);
                        d_left = in_cnt - ONE_N;
                    end
                end
            end
            pse_pkg::M_INSERT: begin
                if (r_count == '0) begin
                    d_st = pse_pkg::ST_EMPTY;
                end else if (in_pos == '0 || in_pos > r_count) begin
                    d_st = pse_pkg::ST_BAD;
                end else if (r_count >= FULL_N) begin
                    d_st = pse_pkg::ST_FULL;
                end else begin
                    d_kind = pse_pkg::SH_UP;
                    d_at   = IW'(in_pos - ONE_N);
                    d_fill = r_count + ONE_N;
                end
            end
            pse_pkg::M_READ: begin
                if (r_count == '0) begin
                    d_st = pse_pkg::ST_EMPTY;
                end else if (in_pos == '0 || in_pos > r_count) begin
                    d_st = pse_pkg::ST_BAD;
                end else begin
                    d_rv = rd_word;
                end
            end
            pse_pkg::M_CLEAR: begin
                d_fill = '0;
            end
            default: begin
                d_st = pse_pkg::ST_BAD;
            end
        endcase
    end

    // broadcast to the cell row
    always_comb begin
        cell_ctl.sel  = XW'(d_sel);
        cell_ctl.word = in_word;
        if (in_xfer) begin
            cell_ctl.kind = d_kind;
            cell_ctl.at   = XW'(d_at);
        end else if (r_state == S_SHIFT) begin
            cell_ctl.kind = pse_pkg::SH_DOWN;
            cell_ctl.at   = XW'(r_at);
        end else begin
            cell_ctl.kind = pse_pkg::SH_HOLD;
            cell_ctl.at   = '0;
        end
    end

    // the cell row; ends see zero, never kept inside the fill
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WW-1:0] from_up;
        logic [WW-1:0] from_down;

        if (g == DEPTH - 1) begin : g_top
            assign from_up = '0;
        end else begin : g_mid_up
            assign from_up = cell_data[g + 1];
        end

        if (g == 0) begin : g_bot
            assign from_down = '0;
        end else begin : g_mid_down
            assign from_down = cell_data[g - 1];
        end

        pse_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_from_up   (from_up),
            .i_from_down (from_down),
            .o_data      (cell_data[g]),
            .o_tap       (cell_tap[g])
        );
    end

    // sequencer, pending slot and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_left       <= '0;
            r_at         <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            // pending result moves to the output when it is free
            if (r_pend_valid && out_free) begin
                r_o_data     <= {r_pend_fill, r_pend_st, r_pend_rv};
                r_o_valid    <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (m_axis_tready) begin
                r_o_valid    <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_pend_rv   <= d_rv;
                        r_pend_st   <= d_st;
                        r_pend_fill <= d_fill;
                        r_count     <= d_fill;
                        if (d_kind == pse_pkg::SH_DOWN && d_left != '0) begin
                            r_state <= S_SHIFT;
                            r_left  <= d_left;
                            r_at    <= d_at;
                        end else begin
                            r_pend_valid <= 1'b1;
                        end
                    end
                end
                S_SHIFT: begin
                    // one place down per cycle until the run is gone
                    r_left <= r_left - ONE_N;
                    if (r_left == ONE_N) begin
                        r_state      <= S_IDLE;
                        r_pend_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_W'(r_o_data);

endmodule
